### rtl/indexed_ordered_list_store_defines.svh
// Assertion helpers used by the list store RTL.
`ifndef INDEXED_ORDERED_LIST_STORE_DEFINES_SVH
`define INDEXED_ORDERED_LIST_STORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define IOLS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("List store check failed.");

// Next-cycle implication, sampled on clk and disabled during reset.
`define IOLS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("List store check failed.");

`endif

### rtl/iols_pkg.sv
package iols_pkg;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    // Wide enough for any cell index and count up to the largest depth.
    localparam int PTR_W    = 13;

    localparam logic [MODE_W-1:0] MD_INS_HEAD = 3'd0;
    localparam logic [MODE_W-1:0] MD_INS_TAIL = 3'd1;
    localparam logic [MODE_W-1:0] MD_INS_AT   = 3'd2;
    localparam logic [MODE_W-1:0] MD_DEL_HEAD = 3'd3;
    localparam logic [MODE_W-1:0] MD_DEL_TAIL = 3'd4;
    localparam logic [MODE_W-1:0] MD_DEL_AT   = 3'd5;
    localparam logic [MODE_W-1:0] MD_READ     = 3'd6;
    localparam logic [MODE_W-1:0] MD_RSVD     = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INSERT,
        SH_DELETE
    } shift_op_t;

    typedef struct packed {
        shift_op_t          op;
        logic               rd;
        logic [PTR_W-1:0]   point;
        logic [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

### rtl/iols_req_if.sv
interface iols_req_if;
    import iols_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   position;
    logic [DATA_W-1:0]  value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

### rtl/iols_rsp_if.sv
interface iols_rsp_if;
    import iols_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    read_value;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   element_count;

    modport source (output valid, output read_value, output status, output element_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input element_count,
                    output ready);
endinterface

### rtl/iols_cell.sv
module iols_cell #(
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  iols_pkg::cell_ctrl_t        ctrl,
    input  logic [iols_pkg::DATA_W-1:0] prev_data,
    input  logic [iols_pkg::DATA_W-1:0] next_data,
    output logic [iols_pkg::DATA_W-1:0] data,
    output logic [iols_pkg::DATA_W-1:0] tap
);
    import iols_pkg::*;

    localparam logic [PTR_W-1:0] MY_IDX = PTR_W'(IDX);

    logic [DATA_W-1:0] data_reg, data_next;
    logic [DATA_W-1:0] tap_reg, tap_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            SH_INSERT:
            begin
                if (MY_IDX > ctrl.point)
                begin
                    data_next = prev_data;
                end
                else if (MY_IDX == ctrl.point)
                begin
                    data_next = ctrl.value;
                end
            end
            SH_DELETE:
            begin
                if (MY_IDX >= ctrl.point)
                begin
                    data_next = next_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
        tap_next = (ctrl.rd && (MY_IDX == ctrl.point)) ? data_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        tap_reg  <= tap_next;
    end

    assign data = data_reg;
    assign tap  = tap_reg;
endmodule

### rtl/indexed_ordered_list_store.sv
// Ordered list store of signed 32-bit values, up to DEPTH entries, head at index 0.
// The request channel carries mode, position and value; the response channel
// returns read_value, status and element_count, one response per request.
// Entries sit in a row of cells; an insert or delete shifts every cell after the
// chosen point by one place at once, each cell taking its neighbor's data.
// A read gates the addressed cell onto a tap, and the taps are ORed in groups of
// eight into registers, then across the groups into the response register.
// A request is taken only when the control is idle; its response is loaded after
// the execute, group and finish steps, and only then is the next request taken.
// The next request is taken while an earlier response still waits on the
// response channel; if the receiver stalls, the following request holds in its
// last step until the response register is free.
// Reset empties the list and drops any pending response; entry contents are not
// cleared, since only entries below the element count are ever read.
`include "indexed_ordered_list_store_defines.svh"

module indexed_ordered_list_store #(
    parameter int DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    iols_req_if.sink      req,
    iols_rsp_if.source    rsp
);
    import iols_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int GRP = 8;
    localparam int NG  = (DEPTH + GRP - 1) / GRP;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GROUP,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        count_reg, count_next;
    cell_ctrl_t           ctrl_reg, ctrl_next, cell_ctrl;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 rd_ok_reg, rd_ok_next;

    logic                 rsp_valid_reg;
    logic [DATA_W-1:0]    rsp_value_reg;
    logic [STATUS_W-1:0]  rsp_status_reg;
    logic [COUNT_W-1:0]   rsp_count_reg;

    logic [DATA_W-1:0]    cell_data [DEPTH];
    logic [DATA_W-1:0]    cell_tap [DEPTH];
    logic [DATA_W-1:0]    group_reg [NG];
    logic [DATA_W-1:0]    group_next [NG];
    logic [DATA_W-1:0]    gather;

    logic [PTR_W-1:0]     cnt_p, pos_p;
    logic                 full, empty, accept, rsp_free;

    assign cnt_p    = PTR_W'(count_reg);
    assign pos_p    = PTR_W'(req.position);
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign accept   = req.valid && req.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        status_next     = ST_OK;
        rd_ok_next      = 1'b0;
        count_next      = count_reg;
        ctrl_next.op    = SH_HOLD;
        ctrl_next.rd    = 1'b0;
        ctrl_next.point = pos_p;
        ctrl_next.value = req.value;
        unique case (req.mode) inside
            MD_INS_HEAD, MD_INS_TAIL, MD_INS_AT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if ((req.mode == MD_INS_AT) && (pos_p > cnt_p))
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    ctrl_next.op = SH_INSERT;
                    if (req.mode == MD_INS_HEAD)
                    begin
                        ctrl_next.point = '0;
                    end
                    else if (req.mode == MD_INS_TAIL)
                    begin
                        ctrl_next.point = cnt_p;
                    end
                    count_next = count_reg + CW'(1);
                end
            end
            MD_DEL_HEAD, MD_DEL_TAIL:
            begin
                if (empty)
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    ctrl_next.op    = SH_DELETE;
                    ctrl_next.point = (req.mode == MD_DEL_HEAD) ? '0 : cnt_p - PTR_W'(1);
                    count_next      = count_reg - CW'(1);
                end
            end
            MD_DEL_AT:
            begin
                if (pos_p >= cnt_p)
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    ctrl_next.op = SH_DELETE;
                    count_next   = count_reg - CW'(1);
                end
            end
            MD_READ:
            begin
                if (pos_p >= cnt_p)
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    ctrl_next.rd = 1'b1;
                    rd_ok_next   = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        cell_ctrl = ctrl_reg;
        if (state_reg != S_EXEC)
        begin
            cell_ctrl.op = SH_HOLD;
            cell_ctrl.rd = 1'b0;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] prev_d, next_d;
        if (i == 0)
        begin : g_first
            assign prev_d = '0;
        end
        else
        begin : g_mid_prev
            assign prev_d = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign next_d = '0;
        end
        else
        begin : g_mid_next
            assign next_d = cell_data[i+1];
        end
        iols_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i]),
            .tap       (cell_tap[i])
        );
    end

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GRP; k++)
            begin
                if (g * GRP + k < DEPTH)
                begin
                    group_next[g] = group_next[g] | cell_tap[g * GRP + k];
                end
            end
        end
        gather = '0;
        for (int g = 0; g < NG; g++)
        begin
            gather = gather | group_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_GROUP)
        begin
            group_reg <= group_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ctrl_reg       <= '0;
            status_reg     <= ST_OK;
            rd_ok_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_value_reg  <= '0;
            rsp_status_reg <= ST_OK;
            rsp_count_reg  <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ctrl_reg   <= ctrl_next;
                        status_reg <= status_next;
                        rd_ok_reg  <= rd_ok_next;
                        count_reg  <= count_next;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_GROUP;
                end
                S_GROUP:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= status_reg;
                        rsp_count_reg  <= COUNT_W'(count_reg);
                        if (status_reg != ST_OK)
                        begin
                            rsp_value_reg <= '1;
                        end
                        else if (rd_ok_reg)
                        begin
                            rsp_value_reg <= gather;
                        end
                        else
                        begin
                            rsp_value_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_value    = rsp_value_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.element_count = rsp_count_reg;

    `IOLS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `IOLS_ASSERT_NXT(a_full_keeps_count, accept && (status_next == ST_FULL), count_reg == $past(count_reg))
    `IOLS_ASSERT_IMP(a_error_value, rsp.valid && (rsp.status != ST_OK), rsp.read_value == '1)
    `IOLS_ASSERT_NXT(a_finish_loads, (state_reg == S_FINISH) && rsp_free, rsp_valid_reg && (state_reg == S_IDLE))
endmodule
